// ===== src/swrf_pkg.sv =====
// Shared constants and types of the spherical wall repulsion force unit.
package swrf_pkg;

	localparam logic [1:0] REG_WALL_ENABLED = 2'd0;
	localparam logic [1:0] REG_WALL_RADIUS  = 2'd1;
	localparam logic [1:0] REG_FORCE_SCALE  = 2'd2;
	localparam logic [1:0] REG_DECAY_LENGTH = 2'd3;

	localparam logic [30:0] RADIUS_RESET = 31'd65536;
	localparam logic [30:0] DECAY_RESET  = 31'd65536;
	localparam logic [31:0] SCALE_RESET  = 32'd0;

	localparam logic [30:0] EXP_NEG_ONE = 31'd1580030169;

	localparam int TAYLOR_TERMS   = 16;
	localparam int RECIP_SHIFT    = 36;
	localparam int POWER_STEPS    = 31;
	localparam int EXP_DIV_BITS   = 37;
	localparam int FORCE_DIV_BITS = 32;

	typedef struct packed {
		logic [2:0][31:0] mag_p;
		logic [2:0]       psign;
		logic [30:0]      root;
		logic             kill;
		logic             outside;
	} side_t;

	typedef struct packed {
		logic [2:0][31:0] frc;
		logic             outside;
	} result_t;

endpackage

// ===== src/spherical_wall_repulsion_force_unit.sv =====
// Top level of the spherical wall repulsion force unit.
//
//  Channel  Direction  Payload
//  s_*      in         tdata: pos_x, pos_y, pos_z
//  m_*      out        tdata: force_x, force_y, force_z; tuser: outside_wall
//  cfg_*    in         register write by index
//
// One item enters per cycle while the output queue has room; its result passes through
// the square root, the two dividers and the exp(-1) steps in series.
// Reset clears all valid bits and loads the register reset values.
// A two-entry output queue keeps the pipeline moving while one result waits;
// the whole pipeline stalls only when that queue is full and not drained.
module spherical_wall_repulsion_force_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // pos_x, pos_y, pos_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // force_x, force_y, force_z
	output logic        m_tuser,   // outside_wall
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import swrf_pkg::*;

	logic               enabled_q;
	logic [30:0]        radius_q;
	logic signed [31:0] scale_q;
	logic [30:0]        decay_q;

	logic    en;
	logic    nv;
	side_t   nside;
	logic    ev;
	logic [32:0] ee;
	side_t   eside;
	logic    fv;
	result_t fres;
	result_t qres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			radius_q  <= RADIUS_RESET;
			scale_q   <= SCALE_RESET;
			decay_q   <= DECAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WALL_ENABLED: enabled_q <= cfg_wdata[0];
				REG_WALL_RADIUS:  radius_q  <= cfg_wdata[30:0];
				REG_FORCE_SCALE:  scale_q   <= cfg_wdata;
				REG_DECAY_LENGTH: decay_q   <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign s_tready = en;

	swrf_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.pos         (s_tdata),
		.wall_enabled(enabled_q),
		.wall_radius (radius_q),
		.out_valid   (nv),
		.side_out    (nside)
	);

	swrf_exp u_exp (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (nv),
		.side_in     (nside),
		.wall_radius (radius_q),
		.decay_length(decay_q),
		.out_valid   (ev),
		.e_out       (ee),
		.side_out    (eside)
	);

	swrf_force u_force (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (ev),
		.e_in       (ee),
		.side_in    (eside),
		.force_scale(scale_q),
		.out_valid  (fv),
		.res_out    (fres)
	);

	swrf_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(fv),
		.res_in  (fres),
		.room    (en),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.res_out (qres)
	);

	assign m_tdata = qres.frc;
	assign m_tuser = qres.outside;
endmodule

// ===== src/swrf_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module swrf_udiv #(
	parameter int DW = 31,
	parameter int QB = 32,
	parameter int TW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] rem0,
	input  logic [QB-1:0] lo_bits,
	input  logic [DW-1:0] divisor,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [QB-1:0] quot,
	output logic [TW-1:0] tag_out
);
	logic          v_s   [QB];
	logic [DW-1:0] rem_s [QB];
	logic [DW-1:0] dvs_s [QB];
	logic [QB-1:0] lo_s  [QB];
	logic [QB-1:0] q_s   [QB];
	logic [TW-1:0] tag_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_st
		logic          pv;
		logic [DW-1:0] prem;
		logic [DW-1:0] pdvs;
		logic [QB-1:0] plo;
		logic [QB-1:0] pq;
		logic [TW-1:0] ptag;
		logic [DW:0]   trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign pv   = in_valid;
			assign prem = rem0;
			assign pdvs = divisor;
			assign plo  = lo_bits;
			assign pq   = '0;
			assign ptag = tag_in;
		end else begin : g_next
			assign pv   = v_s[j-1];
			assign prem = rem_s[j-1];
			assign pdvs = dvs_s[j-1];
			assign plo  = lo_s[j-1];
			assign pq   = q_s[j-1];
			assign ptag = tag_s[j-1];
		end

		assign trial = {prem, plo[QB-1]};
		assign ge    = trial >= {1'b0, pdvs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? DW'(trial - {1'b0, pdvs}) : trial[DW-1:0];
				dvs_s[j] <= pdvs;
				lo_s[j]  <= plo << 1;
				q_s[j]   <= {pq[QB-2:0], ge};
				tag_s[j] <= ptag;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign quot      = q_s[QB-1];
	assign tag_out   = tag_s[QB-1];
endmodule

// ===== src/swrf_norm.sv =====
// Squared norm, wall test and pipelined integer square root of the point.
module swrf_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2:0][31:0]    pos,
	input  logic                wall_enabled,
	input  logic [30:0]         wall_radius,
	output logic                out_valid,
	output swrf_pkg::side_t     side_out
);
	import swrf_pkg::*;

	localparam int Steps = 31;

	logic [61:0]      rr_q;
	logic [2:0][31:0] mag_c;
	logic [63:0]      r2_c;
	logic             hit_c;

	logic             v_s1;
	logic [2:0][31:0] mag_s1;
	logic [2:0]       sgn_s1;
	logic [2:0][63:0] sq_s1;

	logic             v_s2;
	logic [61:0]      rad_s2;
	side_t            side_s2;

	logic             v_sq    [Steps];
	logic [61:0]      rad_sq  [Steps];
	logic [31:0]      rem_sq  [Steps];
	side_t            side_sq [Steps];

	always_ff @(posedge clk) begin
		rr_q <= 62'(wall_radius) * 62'(wall_radius);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = pos[i][31] ? (~pos[i]) + 32'd1 : pos[i];
		end
	end

	assign r2_c  = sq_s1[0] + sq_s1[1] + sq_s1[2];
	assign hit_c = r2_c >= 64'(rr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				sgn_s1[i] <= pos[i][31];
				sq_s1[i]  <= 64'(mag_c[i]) * 64'(mag_c[i]);
			end
			rad_s2          <= r2_c[61:0];
			side_s2.mag_p   <= mag_s1;
			side_s2.psign   <= sgn_s1;
			side_s2.root    <= '0;
			side_s2.outside <= wall_enabled && hit_c;
			side_s2.kill    <= !wall_enabled || hit_c || (r2_c == 64'd0);
		end
	end

	for (genvar j = 0; j < Steps; j++) begin : g_sqrt
		logic        pv;
		logic [61:0] prad;
		logic [31:0] prem;
		side_t       pside;
		side_t       nside;
		logic [33:0] cur;
		logic [33:0] trial;
		logic        ge;

		if (j == 0) begin : g_first
			assign pv    = v_s2;
			assign prad  = rad_s2;
			assign prem  = '0;
			assign pside = side_s2;
		end else begin : g_next
			assign pv    = v_sq[j-1];
			assign prad  = rad_sq[j-1];
			assign prem  = rem_sq[j-1];
			assign pside = side_sq[j-1];
		end

		assign cur   = {prem, prad[61:60]};
		assign trial = {1'b0, pside.root, 2'b01};
		assign ge    = cur >= trial;

		always_comb begin
			nside      = pside;
			nside.root = {pside.root[29:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[j] <= 1'b0;
			end else if (en) begin
				v_sq[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_sq[j]  <= prad << 2;
				rem_sq[j]  <= ge ? 32'(cur - trial) : cur[31:0];
				side_sq[j] <= nside;
			end
		end
	end

	assign out_valid = v_sq[Steps-1];
	assign side_out  = side_sq[Steps-1];
endmodule

// ===== src/swrf_exp.sv =====
// Decay argument division and exp(-x) by Taylor series and repeated exp(-1) steps.
module swrf_exp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  swrf_pkg::side_t     side_in,
	input  logic [30:0]         wall_radius,
	input  logic [30:0]         decay_length,
	output logic                out_valid,
	output logic [32:0]         e_out,
	output swrf_pkg::side_t     side_out
);
	import swrf_pkg::*;

	localparam int TagW  = $bits(side_t) + 1;
	localparam int Terms = TAYLOR_TERMS - 1;

	typedef struct packed {
		side_t              side;
		logic               big;
		logic [4:0]         n;
		logic [31:0]        g;
		logic [31:0]        term;
		logic signed [35:0] acc;
	} texp_t;

	logic        v_s1;
	logic [30:0] delta_s1;
	logic [30:0] lambda_s1;
	logic        big_s1;
	side_t       side_s1;
	logic [30:0] lambda_c;
	logic [30:0] delta_c;

	logic                    dv;
	logic [EXP_DIV_BITS-1:0] dq;
	logic [TagW-1:0]         dtag;

	logic  v_t1;
	texp_t base_t1;

	logic        va [Terms];
	texp_t       ba [Terms];
	logic [63:0] prod_a [Terms];
	logic        vb [Terms];
	texp_t       bb [Terms];
	logic [31:0] t_b [Terms];
	logic [67:0] p2_b [Terms];
	logic        vc [Terms];
	texp_t       bc [Terms];

	logic        v_cl;
	logic [32:0] e_cl;
	logic [4:0]  n_cl;
	side_t       side_cl;

	logic        v_pw    [POWER_STEPS];
	logic [32:0] e_pw    [POWER_STEPS];
	logic [4:0]  n_pw    [POWER_STEPS];
	side_t       side_pw [POWER_STEPS];

	assign lambda_c = (decay_length == 31'd0) ? 31'd1 : decay_length;
	assign delta_c  = wall_radius - side_in.root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s1  <= delta_c;
			lambda_s1 <= lambda_c;
			big_s1    <= {5'd0, delta_c} >= {lambda_c, 5'd0};
			side_s1   <= side_in;
		end
	end

	swrf_udiv #(
		.DW(31),
		.QB(EXP_DIV_BITS),
		.TW(TagW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.rem0     (31'(delta_s1 >> 5)),
		.lo_bits  ({delta_s1[4:0], 32'd0}),
		.divisor  (lambda_s1),
		.tag_in   ({big_s1, side_s1}),
		.out_valid(dv),
		.quot     (dq),
		.tag_out  (dtag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0;
		end else if (en) begin
			v_t1 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_t1.side <= dtag[TagW-2:0];
			base_t1.big  <= dtag[TagW-1];
			base_t1.n    <= dq[36:32];
			base_t1.g    <= dq[31:0];
			base_t1.term <= dq[31:0];
			base_t1.acc  <= 36'sh1_0000_0000 - $signed({4'd0, dq[31:0]});
		end
	end

	for (genvar i = 0; i < Terms; i++) begin : g_term
		localparam int K = i + 2;
		localparam logic [35:0] RECIP = 36'((64'd1 << RECIP_SHIFT) / K);

		logic        pv;
		texp_t       pb;
		logic [31:0] tq;
		logic [31:0] qe;
		logic [36:0] rem;
		logic [31:0] qt;
		texp_t       nb;

		if (i == 0) begin : g_first
			assign pv = v_t1;
			assign pb = base_t1;
		end else begin : g_next
			assign pv = vc[i-1];
			assign pb = bc[i-1];
		end

		assign tq  = prod_a[i][63:32];
		assign qe  = p2_b[i][67:36];
		assign rem = 37'(t_b[i]) - 37'(qe) * 37'(K);
		assign qt  = (rem >= 37'(K)) ? qe + 32'd1 : qe;

		always_comb begin
			nb      = bb[i];
			nb.term = qt;
			if ((K % 2) == 1) begin
				nb.acc = bb[i].acc - $signed({4'd0, qt});
			end else begin
				nb.acc = bb[i].acc + $signed({4'd0, qt});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va[i] <= 1'b0;
				vb[i] <= 1'b0;
				vc[i] <= 1'b0;
			end else if (en) begin
				va[i] <= pv;
				vb[i] <= va[i];
				vc[i] <= vb[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ba[i]     <= pb;
				prod_a[i] <= 64'(pb.term) * 64'(pb.g);
				bb[i]     <= ba[i];
				t_b[i]    <= tq;
				p2_b[i]   <= 68'(tq) * 68'(RECIP);
				bc[i]     <= nb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_cl <= 1'b0;
		end else if (en) begin
			v_cl <= vc[Terms-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_cl    <= bc[Terms-1].n;
			side_cl <= bc[Terms-1].side;
			if (bc[Terms-1].big || bc[Terms-1].acc < 36'sd0) begin
				e_cl <= 33'd0;
			end else if (bc[Terms-1].acc > 36'sh1_0000_0000) begin
				e_cl <= 33'h1_0000_0000;
			end else begin
				e_cl <= 33'(bc[Terms-1].acc);
			end
		end
	end

	for (genvar j = 0; j < POWER_STEPS; j++) begin : g_pow
		logic        pv;
		logic [32:0] pe;
		logic [4:0]  pn;
		side_t       ps;
		logic [64:0] prod;

		if (j == 0) begin : g_first
			assign pv = v_cl;
			assign pe = e_cl;
			assign pn = n_cl;
			assign ps = side_cl;
		end else begin : g_next
			assign pv = v_pw[j-1];
			assign pe = e_pw[j-1];
			assign pn = n_pw[j-1];
			assign ps = side_pw[j-1];
		end

		assign prod = 65'(pe) * 65'(EXP_NEG_ONE) + 65'd2147483648;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_pw[j] <= 1'b0;
			end else if (en) begin
				v_pw[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				e_pw[j]    <= (pn > 5'(j)) ? 33'(prod >> 32) : pe;
				n_pw[j]    <= pn;
				side_pw[j] <= ps;
			end
		end
	end

	assign out_valid = v_pw[POWER_STEPS-1];
	assign e_out     = e_pw[POWER_STEPS-1];
	assign side_out  = side_pw[POWER_STEPS-1];
endmodule

// ===== src/swrf_force.sv =====
// Force magnitude, per-axis division by the norm, sign and saturation.
module swrf_force (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [32:0]         e_in,
	input  swrf_pkg::side_t     side_in,
	input  logic signed [31:0]  force_scale,
	output logic                out_valid,
	output swrf_pkg::result_t   res_out
);
	import swrf_pkg::*;

	logic [31:0] absf_c;
	logic [64:0] pm_c;

	logic        v_s1;
	logic [31:0] mag_s1;
	side_t       side_s1;

	logic             v_s2;
	logic [2:0][63:0] n_s2;
	side_t            side_s2;

	logic                      lv   [3];
	logic [FORCE_DIV_BITS-1:0] lq   [3];
	logic [3:0]                ltag [3];
	logic [2:0][31:0]          frc_c;

	logic    v_q;
	result_t res_q;

	assign absf_c = force_scale[31] ? (~force_scale) + 32'd1 : force_scale;
	assign pm_c   = 65'(absf_c) * 65'(e_in) + 65'd2147483648;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_q  <= lv[0] & lv[1] & lv[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= pm_c[63:32];
			side_s1 <= side_in;
			for (int i = 0; i < 3; i++) begin
				n_s2[i] <= 64'(mag_s1) * 64'(side_s1.mag_p[i]);
			end
			side_s2 <= side_s1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic ovf;
		logic sgn;

		assign ovf = n_s2[i][63:32] >= {1'b0, side_s2.root};
		assign sgn = force_scale[31] == side_s2.psign[i];

		swrf_udiv #(
			.DW(31),
			.QB(FORCE_DIV_BITS),
			.TW(4)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_s2),
			.rem0     (n_s2[i][62:32]),
			.lo_bits  (n_s2[i][31:0]),
			.divisor  (side_s2.root),
			.tag_in   ({side_s2.kill, side_s2.outside, sgn, ovf}),
			.out_valid(lv[i]),
			.quot     (lq[i]),
			.tag_out  (ltag[i])
		);

		always_comb begin
			if (ltag[i][3]) begin
				frc_c[i] = 32'd0;
			end else if (ltag[i][1]) begin
				if (ltag[i][0] || lq[i] > 32'h8000_0000) begin
					frc_c[i] = 32'h8000_0000;
				end else begin
					frc_c[i] = (~lq[i]) + 32'd1;
				end
			end else begin
				if (ltag[i][0] || lq[i][31]) begin
					frc_c[i] = 32'h7FFF_FFFF;
				end else begin
					frc_c[i] = lq[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.frc     <= frc_c;
			res_q.outside <= ltag[0][2];
		end
	end

	assign out_valid = v_q;
	assign res_out   = res_q;
endmodule

// ===== src/swrf_outq.sv =====
// Two-entry output queue that decouples the pipeline from the result channel.
module swrf_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  swrf_pkg::result_t   res_in,
	output logic                room,
	output logic                m_tvalid,
	input  logic                m_tready,
	output swrf_pkg::result_t   res_out
);
	import swrf_pkg::*;

	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	result_t    mem_q [2];
	logic       push;
	logic       pop;

	assign m_tvalid = count_q != 2'd0;
	assign pop      = m_tvalid && m_tready;
	assign room     = (count_q != 2'd2) || pop;
	assign push     = in_valid && room;
	assign res_out  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= res_in;
		end
	end
endmodule
